/* hdl/iau_pkg.sv */
// ----------------------------------------------------------------------------
// Indirect address unit package
// Shared widths, codes, types and the special function register map used by
// the pointer register block.
// ----------------------------------------------------------------------------
package iau_pkg;

  localparam int unsigned AddrW = 12;
  localparam int unsigned DataW = 8;
  localparam int unsigned NumPtr = 3;
  localparam int unsigned PtrIdxW = 2;
  localparam int unsigned MapSize = 23;
  localparam int unsigned MapIdxW = 5;

  localparam logic [AddrW-1:0] SFR_BASE_DEFAULT = 12'hFD9;

  typedef enum logic [3:0] {
    K_NONE     = 4'd0,
    K_LOW      = 4'd1,
    K_HIGH     = 4'd2,
    K_BANK     = 4'd3,
    K_INDIRECT = 4'd4,
    K_POSTINC  = 4'd5,
    K_PREINC   = 4'd6,
    K_POSTDEC  = 4'd7,
    K_PLUSW    = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_LOCAL = 2'd1,
    ST_FWD   = 2'd2,
    ST_SUPPR = 2'd3
  } status_e;

  typedef enum logic {
    MODE_READ  = 1'b0,
    MODE_WRITE = 1'b1
  } mode_e;

  typedef struct packed {
    kind_e              kind;
    logic [PtrIdxW-1:0] ptr;
  } map_entry_t;

  typedef struct packed {
    logic             mode;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
    logic [DataW-1:0] wreg_value;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [DataW-1:0] read_data;
    logic [AddrW-1:0] forward_address;
    logic             forward_write;
    logic [DataW-1:0] forward_data;
  } rsp_t;

  typedef struct packed {
    logic               ptr_we;
    logic [PtrIdxW-1:0] ptr_idx;
    logic [AddrW-1:0]   ptr_val;
    logic               bank_we;
    logic [DataW-1:0]   bank_val;
  } upd_t;

  localparam map_entry_t ADDR_MAP [MapSize] = '{
    '{K_LOW, 2'd2}, '{K_HIGH, 2'd2}, '{K_PLUSW, 2'd2}, '{K_PREINC, 2'd2},
    '{K_POSTDEC, 2'd2}, '{K_POSTINC, 2'd2}, '{K_INDIRECT, 2'd2}, '{K_BANK, 2'd0},
    '{K_LOW, 2'd1}, '{K_HIGH, 2'd1}, '{K_PLUSW, 2'd1}, '{K_PREINC, 2'd1},
    '{K_POSTDEC, 2'd1}, '{K_POSTINC, 2'd1}, '{K_INDIRECT, 2'd1}, '{K_NONE, 2'd0},
    '{K_LOW, 2'd0}, '{K_HIGH, 2'd0}, '{K_PLUSW, 2'd0}, '{K_PREINC, 2'd0},
    '{K_POSTDEC, 2'd0}, '{K_POSTINC, 2'd0}, '{K_INDIRECT, 2'd0}
  };

  // Addresses below the base or past the end of the map belong elsewhere.
  function automatic map_entry_t map_decode(logic [AddrW-1:0] addr,
                                            logic [AddrW-1:0] base);
    logic [AddrW-1:0] off;
    map_entry_t       e;
    off = addr - base;
    e   = '{K_NONE, '0};
    if (addr >= base && off < AddrW'(MapSize)) begin
      e = ADDR_MAP[off[MapIdxW-1:0]];
    end
    return e;
  endfunction

endpackage

/* hdl/iau_req_if.sv */
// ----------------------------------------------------------------------------
// Indirect address unit request channel
// Valid/ready channel carrying one data-bus access item.
// ----------------------------------------------------------------------------
interface iau_req_if import iau_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [AddrW-1:0] address;
  logic [DataW-1:0] write_data;
  logic [DataW-1:0] wreg_value;

  modport source (output valid, output mode, output address, output write_data,
                  output wreg_value, input ready);
  modport sink (input valid, input mode, input address, input write_data,
                input wreg_value, output ready);
endinterface

/* hdl/iau_rsp_if.sv */
// ----------------------------------------------------------------------------
// Indirect address unit response channel
// Valid/ready channel carrying one access result item.
// ----------------------------------------------------------------------------
interface iau_rsp_if import iau_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [DataW-1:0] read_data;
  logic [AddrW-1:0] forward_address;
  logic             forward_write;
  logic [DataW-1:0] forward_data;

  modport source (output valid, output status, output read_data,
                  output forward_address, output forward_write,
                  output forward_data, input ready);
  modport sink (input valid, input status, input read_data,
                input forward_address, input forward_write,
                input forward_data, output ready);
endinterface

/* hdl/iau_resolve.sv */
// ----------------------------------------------------------------------------
// Indirect address unit resolver
// Decodes one access against the register map, produces its result and the
// pointer or bank select update that it causes.
// ----------------------------------------------------------------------------
module iau_resolve import iau_pkg::*; #(
  parameter logic [AddrW-1:0] SFR_BASE_ADDRESS = SFR_BASE_DEFAULT
) (
  input  req_t             req_i,
  input  logic [AddrW-1:0] ptr_i [NumPtr],
  input  logic [DataW-1:0] bank_i,
  output rsp_t             rsp_o,
  output upd_t             upd_o
);

  map_entry_t       e;
  logic [AddrW-1:0] p;
  logic [AddrW-1:0] p_inc;
  logic [AddrW-1:0] p_dec;
  logic [AddrW-1:0] p_plusw;
  logic [AddrW-1:0] target;
  status_e          status;
  logic [DataW-1:0] rdata;
  logic             is_write;
  map_entry_t       te;

  always_comb begin
    e        = map_decode(req_i.address, SFR_BASE_ADDRESS);
    is_write = (req_i.mode == MODE_WRITE);
    unique case (e.ptr)
      2'd0:    p = ptr_i[0];
      2'd1:    p = ptr_i[1];
      default: p = ptr_i[2];
    endcase
    p_inc   = p + AddrW'(1);
    p_dec   = p - AddrW'(1);
    p_plusw = p + AddrW'(req_i.wreg_value);
    target  = p;
    status  = ST_NONE;
    rdata   = '0;
    upd_o   = '{ptr_we: 1'b0, ptr_idx: e.ptr, ptr_val: p, bank_we: 1'b0,
                bank_val: req_i.write_data};
    unique case (e.kind)
      K_LOW: begin
        status = ST_LOCAL;
        if (is_write) begin
          upd_o.ptr_we  = 1'b1;
          upd_o.ptr_val = {p[AddrW-1:DataW], req_i.write_data};
        end else begin
          rdata = p[DataW-1:0];
        end
      end
      K_HIGH: begin
        status = ST_LOCAL;
        if (is_write) begin
          upd_o.ptr_we  = 1'b1;
          upd_o.ptr_val = {req_i.write_data[AddrW-DataW-1:0], p[DataW-1:0]};
        end else begin
          rdata = DataW'(p[AddrW-1:DataW]);
        end
      end
      K_BANK: begin
        status = ST_LOCAL;
        if (is_write) begin
          upd_o.bank_we = 1'b1;
        end else begin
          rdata = bank_i;
        end
      end
      K_INDIRECT: begin
        status = ST_FWD;
      end
      K_POSTINC: begin
        status        = ST_FWD;
        upd_o.ptr_we  = 1'b1;
        upd_o.ptr_val = p_inc;
      end
      K_PREINC: begin
        status        = ST_FWD;
        target        = p_inc;
        upd_o.ptr_we  = 1'b1;
        upd_o.ptr_val = p_inc;
      end
      K_POSTDEC: begin
        status        = ST_FWD;
        upd_o.ptr_we  = 1'b1;
        upd_o.ptr_val = p_dec;
      end
      K_PLUSW: begin
        status = ST_FWD;
        target = p_plusw;
      end
      default: begin
        status = ST_NONE;
      end
    endcase

    // An alias that resolves onto another alias is not forwarded.
    te = map_decode(target, SFR_BASE_ADDRESS);
    if (status == ST_FWD && te.kind >= K_INDIRECT) begin
      status = ST_SUPPR;
    end

    rsp_o.status          = status;
    rsp_o.read_data       = rdata;
    rsp_o.forward_address = (status == ST_FWD) ? target : '0;
    rsp_o.forward_write   = (status == ST_FWD) && is_write;
    rsp_o.forward_data    = (status == ST_FWD && is_write) ? req_i.write_data : '0;
  end

endmodule

/* hdl/indirect_address_unit_core.sv */
// ----------------------------------------------------------------------------
// Indirect address unit core
// Pointer registers, bank select and their aliases for a data bus.
// ----------------------------------------------------------------------------
// The request channel carries one data-bus access per item: read or write,
// the 12-bit address, the write byte and the current working register. The
// response channel returns one item per request with a status code, the
// local read byte and, for indirect accesses, the resolved address and the
// write byte to be carried out by the surrounding bus.
// A request is taken into an input register, resolved by the decoder and
// pointer adder while it sits there, and the result is then held in an
// output register. One item is accepted every cycle while the receiver
// takes results; the pointer adder sits in a single stage, so each item
// sees the pointer values left by the one before it.
// When the receiver stalls, the result register holds its item and the
// input register still accepts one further item; the request channel then
// drops ready until the result is taken.
// Reset clears all three pointers, bank select and both valid flags.
// ----------------------------------------------------------------------------
module indirect_address_unit_core import iau_pkg::*; #(
  parameter logic [AddrW-1:0] SFR_BASE_ADDRESS = SFR_BASE_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  iau_req_if.sink   req_i,
  iau_rsp_if.source rsp_o
);

  logic             in_valid_q, in_valid_d;
  req_t             in_q;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q;
  logic [AddrW-1:0] ptr_q [NumPtr];
  logic [DataW-1:0] bank_q;
  logic             req_fire;
  logic             stage_adv;
  logic             stage_fire;
  rsp_t             res;
  upd_t             upd;

  assign stage_adv   = !out_valid_q || rsp_o.ready;
  assign stage_fire  = in_valid_q && stage_adv;
  assign req_i.ready = !in_valid_q || stage_adv;
  assign req_fire    = req_i.valid && req_i.ready;

  assign in_valid_d  = req_fire ? 1'b1 : (stage_adv ? 1'b0 : in_valid_q);
  assign out_valid_d = stage_adv ? in_valid_q : out_valid_q;

  iau_resolve #(
    .SFR_BASE_ADDRESS(SFR_BASE_ADDRESS)
  ) u_resolve (
    .req_i (in_q),
    .ptr_i (ptr_q),
    .bank_i(bank_q),
    .rsp_o (res),
    .upd_o (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumPtr; i++) begin
        ptr_q[i] <= '0;
      end
      bank_q <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (stage_fire && upd.ptr_we) begin
        ptr_q[upd.ptr_idx] <= upd.ptr_val;
      end
      if (stage_fire && upd.bank_we) begin
        bank_q <= upd.bank_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      in_q <= '{mode: req_i.mode, address: req_i.address,
                write_data: req_i.write_data, wreg_value: req_i.wreg_value};
    end
    if (stage_fire) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_q.status;
  assign rsp_o.read_data       = out_q.read_data;
  assign rsp_o.forward_address = out_q.forward_address;
  assign rsp_o.forward_write   = out_q.forward_write;
  assign rsp_o.forward_data    = out_q.forward_data;

  a_state_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_fire |=> $stable({ptr_q[0], ptr_q[1], ptr_q[2], bank_q}))
    else $error("Pointer state changed without an item being resolved.");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> req_i.ready)
    else $error("Request refused while the result register is empty.");

  a_no_fwd_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_FWD) |->
      (out_q.forward_address == '0 && !out_q.forward_write &&
       out_q.forward_data == '0))
    else $error("Forwarding fields set on an item that is not forwarded.");

  a_suppr_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_SUPPR) |-> out_q.read_data == '0)
    else $error("Suppressed access returned read data.");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !stage_adv) |=> (in_valid_q && $stable(in_q)))
    else $error("Input register lost an item during a stall.");

endmodule
